// ===== rtl/kvt_pkg.sv =====
// Shared types and constants for the key velocity tracker.
// Depends on nothing; every other file refers to it by scoped names.

package kvt_pkg;

   // Phase of one key cell.
   typedef enum logic [1:0] {
      PHASE_REST  = 2'd0,
      PHASE_ARMED = 2'd1,
      PHASE_HELD  = 2'd2
   } phase_type;

   // Event codes carried by a result item.
   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_LOOKUP   = 3'd1,
      ST_DIV_LOAD = 3'd2,
      ST_DIVIDE   = 3'd3,
      ST_EMIT     = 3'd4
   } kvt_state_type;

   // One entry of the cell memory.
   typedef struct packed {
      phase_type   phase;
      logic [31:0] arm_time;
   } kvt_entry_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BAND_LOW  = 3'd0;
   localparam logic [2:0] CSR_BAND_HIGH = 3'd1;
   localparam logic [2:0] CSR_RELEASE   = 3'd2;
   localparam logic [2:0] CSR_FAST_TIME = 3'd3;
   localparam logic [2:0] CSR_SLOW_TIME = 3'd4;

   // Configuration reset values.
   localparam logic [11:0] BAND_LOW_RESET  = 12'd1229;
   localparam logic [11:0] BAND_HIGH_RESET = 12'd3277;
   localparam logic [11:0] RELEASE_RESET   = 12'd819;
   localparam logic [15:0] FAST_TIME_RESET = 16'd2;
   localparam logic [15:0] SLOW_TIME_RESET = 16'd50;

   // Velocity scale: full velocity and the number of quotient bits.
   localparam int unsigned VEL_BITS = 10;
   localparam logic [9:0]  VEL_MAX  = 10'd1023;

endpackage

// ===== rtl/kvt_cell_mem.sv =====
// Cell state memory: phase and arming time of every key cell, one entry per cell.
// Synchronous single-read, single-write array with a registered read; uses kvt_pkg.

module kvt_cell_mem #(
   parameter int NUM_CELLS = 64,
   parameter int CELL_AW   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [CELL_AW-1:0]    rd_addr,
   output kvt_pkg::kvt_entry_type rd_data,
   input  logic                  wr_en,
   input  logic [CELL_AW-1:0]    wr_addr,
   input  kvt_pkg::kvt_entry_type wr_data
);

   kvt_pkg::kvt_entry_type entry_mem_ff [NUM_CELLS];
   kvt_pkg::kvt_entry_type rd_data_ff;
   logic [NUM_CELLS-1:0]   valid_ff;
   logic                   rd_valid_ff;

   // Storage array: write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // One valid bit per cell, so that every cell reads as resting after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A never-written cell is at rest; its arming time is never looked at.
   always_comb begin
      rd_data = rd_data_ff;
      if (!rd_valid_ff) begin
         rd_data.phase = kvt_pkg::PHASE_REST;
      end
   end

endmodule

// ===== rtl/kvt_vel_div.sv =====
// Iterative velocity divider: (span * 1023) / divisor, one quotient bit per cycle.
// Restoring division over ten steps; uses kvt_pkg for the velocity width.

module kvt_vel_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] span,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [9:0]  quotient
);

   localparam logic [3:0] LAST_STEP = 4'(kvt_pkg::VEL_BITS - 1);

   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  count_ff;
   logic [15:0] rem_ff;
   logic [9:0]  shf_ff;
   logic [15:0] divisor_ff;
   logic [25:0] numer;
   logic [16:0] trial;

   // span * 1023 as a shift and a subtract.
   assign numer = {span, 10'b0} - {10'b0, span};

   // Trial subtraction of the divisor from the partial remainder.
   assign trial = {rem_ff, shf_ff[9]} - {1'b0, divisor_ff};

   // Control: busy flag, step count and a one-cycle done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 4'd1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the numerator's upper part seeds the remainder, since the
   // quotient always fits in ten bits; the low bits shift out as quotient bits
   // shift in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= numer[25:10];
         shf_ff     <= numer[9:0];
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_ff <= trial[15:0];
         end else begin
            rem_ff <= {rem_ff[14:0], shf_ff[9]};
         end
         shf_ff <= {shf_ff[8:0], ~trial[16]};
      end
   end

   assign done     = done_ff;
   assign quotient = shf_ff;

endmodule

// ===== rtl/key_velocity_tracker_unit.sv =====
// Key velocity tracker: each item is one depth sample for one key cell and
// gives exactly one result item (press with velocity, release, or no event).
// Items are handled one at a time. A sample that needs no division is read from
// the cell memory, updates it and loads the output register before the next
// item is accepted; the load waits while the output register still holds an
// unaccepted result. A press whose crossing time lies strictly between the fast
// and slow times first runs the iterative divider, one velocity bit per cycle.
// The output register holds a finished result while the next item is read in.
// Every cell reads as resting straight after reset; no clearing pass.
// Depends on kvt_pkg, kvt_cell_mem and kvt_vel_div.

module key_velocity_tracker_unit #(
   parameter int NUM_CELLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Sample input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_cell_index,
   input  logic [11:0] req_position,
   input  logic [31:0] req_time_ms,
   // Event output channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_event_cell,
   output logic [9:0]  rsp_velocity,
   output logic        rsp_is_held,
   // Configuration write port.
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

   // Configuration registers.
   logic [11:0] band_low_ff;
   logic [11:0] band_high_ff;
   logic [11:0] release_ff;
   logic [15:0] fast_time_ff;
   logic [15:0] slow_time_ff;

   // Sequencer.
   kvt_pkg::kvt_state_type state_ff, state_in;

   // Captured item and staged result.
   logic [7:0]  cell_ff;
   logic [11:0] pos_ff;
   logic [31:0] time_ff;
   kvt_pkg::event_kind_type kind_ff;
   logic [9:0]  vel_ff;
   logic        held_ff;
   logic        need_div_ff;
   logic [15:0] div_span_ff;
   logic [15:0] div_divisor_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   kvt_pkg::event_kind_type rsp_kind_ff;
   logic [7:0]  rsp_cell_ff;
   logic [9:0]  rsp_vel_ff;
   logic        rsp_held_ff;

   // Memory and divider connections.
   logic                   mem_rd_en;
   logic                   mem_wr_en;
   kvt_pkg::kvt_entry_type mem_rd_data;
   kvt_pkg::kvt_entry_type mem_wr_data;
   logic                   div_start;
   logic                   div_done;
   logic [9:0]             div_quotient;

   // Cell update results.
   logic                    in_range;
   kvt_pkg::phase_type      next_phase;
   logic [31:0]             next_arm;
   kvt_pkg::event_kind_type next_kind;
   logic [31:0]             elapsed;
   logic                    fast_hit;
   logic                    slow_hit;
   logic                    load_rsp;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff  <= kvt_pkg::BAND_LOW_RESET;
         band_high_ff <= kvt_pkg::BAND_HIGH_RESET;
         release_ff   <= kvt_pkg::RELEASE_RESET;
         fast_time_ff <= kvt_pkg::FAST_TIME_RESET;
         slow_time_ff <= kvt_pkg::SLOW_TIME_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            kvt_pkg::CSR_BAND_LOW:  band_low_ff  <= csr_write_data[11:0];
            kvt_pkg::CSR_BAND_HIGH: band_high_ff <= csr_write_data[11:0];
            kvt_pkg::CSR_RELEASE:   release_ff   <= csr_write_data[11:0];
            kvt_pkg::CSR_FAST_TIME: fast_time_ff <= csr_write_data;
            kvt_pkg::CSR_SLOW_TIME: slow_time_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   kvt_cell_mem #(
      .NUM_CELLS (NUM_CELLS),
      .CELL_AW   (CELL_AW)
   ) u_cell_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (req_cell_index[CELL_AW-1:0]),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (cell_ff[CELL_AW-1:0]),
      .wr_data (mem_wr_data)
   );

   kvt_vel_div u_vel_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .span     (div_span_ff),
      .divisor  (div_divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Phase update of the addressed cell; arming and firing cascade in one sample.
   assign in_range = {1'b0, cell_ff} < 9'(NUM_CELLS);

   always_comb begin
      next_phase = mem_rd_data.phase;
      next_arm   = mem_rd_data.arm_time;
      next_kind  = kvt_pkg::EV_NONE;
      if (next_phase == kvt_pkg::PHASE_REST && pos_ff >= band_low_ff) begin
         next_phase = kvt_pkg::PHASE_ARMED;
         next_arm   = time_ff;
      end
      case (next_phase)
         kvt_pkg::PHASE_ARMED: begin
            if (pos_ff >= band_high_ff) begin
               next_kind  = kvt_pkg::EV_PRESS;
               next_phase = kvt_pkg::PHASE_HELD;
            end else if (pos_ff < band_low_ff) begin
               next_phase = kvt_pkg::PHASE_REST;
            end
         end
         kvt_pkg::PHASE_HELD: begin
            if (pos_ff <= release_ff) begin
               next_kind  = kvt_pkg::EV_RELEASE;
               next_phase = kvt_pkg::PHASE_REST;
            end
         end
         default: ;
      endcase
      mem_wr_data.phase    = next_phase;
      mem_wr_data.arm_time = next_arm;
   end

   // Crossing time, modulo 2^32, and the two clamp tests.
   assign elapsed  = time_ff - next_arm;
   assign fast_hit = elapsed <= {16'b0, fast_time_ff};
   assign slow_hit = elapsed >= {16'b0, slow_time_ff};

   // Sequencer: next state and control strobes.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         kvt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mem_rd_en = 1'b1;
               state_in  = kvt_pkg::ST_LOOKUP;
            end
         end
         kvt_pkg::ST_LOOKUP: begin
            mem_wr_en = in_range;
            state_in  = (in_range && next_kind == kvt_pkg::EV_PRESS && !fast_hit && !slow_hit)
                        ? kvt_pkg::ST_DIV_LOAD : kvt_pkg::ST_EMIT;
         end
         kvt_pkg::ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = kvt_pkg::ST_DIVIDE;
         end
         kvt_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = kvt_pkg::ST_EMIT;
            end
         end
         kvt_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = kvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kvt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture of the accepted item.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cell_ff <= req_cell_index;
         pos_ff  <= req_position;
         time_ff <= req_time_ms;
      end
   end

   // Result staging: event, clamped velocity and divider operands.
   always_ff @(posedge clock) begin
      if (state_ff == kvt_pkg::ST_LOOKUP) begin
         kind_ff        <= in_range ? next_kind : kvt_pkg::EV_NONE;
         held_ff        <= in_range && next_phase == kvt_pkg::PHASE_HELD;
         need_div_ff    <= !fast_hit && !slow_hit;
         div_span_ff    <= slow_time_ff - elapsed[15:0];
         div_divisor_ff <= slow_time_ff - fast_time_ff;
         if (in_range && next_kind == kvt_pkg::EV_PRESS && fast_hit) begin
            vel_ff <= kvt_pkg::VEL_MAX;
         end else begin
            vel_ff <= '0;
         end
      end else if (state_ff == kvt_pkg::ST_DIVIDE && div_done) begin
         vel_ff <= div_quotient;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_kind_ff <= kind_ff;
         rsp_cell_ff <= cell_ff;
         rsp_vel_ff  <= vel_ff;
         rsp_held_ff <= held_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_event_cell = rsp_cell_ff;
   assign rsp_velocity   = rsp_vel_ff;
   assign rsp_is_held    = rsp_held_ff;

`ifndef NO_ASSERTIONS
   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == kvt_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide state");

   // A divided press only happens when the crossing time lies between the limits.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == kvt_pkg::ST_DIV_LOAD |-> need_div_ff && kind_ff == kvt_pkg::EV_PRESS)
      else $error("division started for an item that needs none");

   // The cell memory is written only during the update cycle of an item.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff == kvt_pkg::ST_LOOKUP && !mem_rd_en)
      else $error("cell memory written outside the update cycle");

   // Only a press carries a velocity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_vel_ff != '0 |-> rsp_kind_ff == kvt_pkg::EV_PRESS)
      else $error("velocity on an item that is not a press");

   // A press leaves the cell held and a release leaves it resting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff != kvt_pkg::EV_PRESS || rsp_held_ff)
                       && (rsp_kind_ff != kvt_pkg::EV_RELEASE || !rsp_held_ff))
      else $error("held flag disagrees with the event");
`endif

endmodule

// ===== tb/key_velocity_tracker_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_velocity_tracker_unit: directed and random key strokes
// against an in-bench phase and velocity predictor, with random idling on both channels.
// Depends on kvt_pkg and the key_velocity_tracker_unit RTL.

module key_velocity_tracker_unit_tb;

   localparam int CELLS          = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int QUIET_CYCLES   = 4;
   localparam int ITEMS_PER_SET  = 200;

   // One predicted result item.
   typedef struct packed {
      kvt_pkg::event_kind_type kind;
      logic [7:0]              cell_id;
      logic [9:0]              velocity;
      logic                    held;
   } key_event_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_cell_index;
   logic [11:0] req_position;
   logic [31:0] req_time_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_event_cell;
   logic [9:0]  rsp_velocity;
   logic        rsp_is_held;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   // Predictor state: per-cell phase and arming time, plus the register copies.
   kvt_pkg::phase_type cell_phase [CELLS];
   logic [31:0]        cell_arm_ms [CELLS];
   logic [11:0]        cfg_band_low  = kvt_pkg::BAND_LOW_RESET;
   logic [11:0]        cfg_band_high = kvt_pkg::BAND_HIGH_RESET;
   logic [11:0]        cfg_release   = kvt_pkg::RELEASE_RESET;
   logic [15:0]        cfg_fast_ms   = kvt_pkg::FAST_TIME_RESET;
   logic [15:0]        cfg_slow_ms   = kvt_pkg::SLOW_TIME_RESET;

   key_event_type pending_events[$];
   int            error_count = 0;
   int            sample_count = 0;
   int            idle_cycles = 0;
   bit            idle_on = 1'b1;
   bit            stall_on = 1'b1;

   key_velocity_tracker_unit #(.NUM_CELLS(CELLS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_index   (req_cell_index),
      .req_position     (req_position),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_cell   (rsp_event_cell),
      .rsp_velocity     (rsp_velocity),
      .rsp_is_held      (rsp_is_held),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Works out the result of one sample and advances the cell's phase.
   function automatic key_event_type predict_key_event(logic [7:0] cell_idx,
                                                       logic [11:0] pos,
                                                       logic [31:0] now);
      key_event_type      ev;
      kvt_pkg::phase_type ph;
      logic [31:0]        elapsed;
      logic [63:0]        num;
      logic [63:0]        span;
      ev.kind     = kvt_pkg::EV_NONE;
      ev.cell_id  = cell_idx;
      ev.velocity = '0;
      ev.held     = 1'b0;
      if (cell_idx < CELLS) begin
         ph = cell_phase[cell_idx];
         // A resting cell arms on reaching the lower band and may press in the same sample.
         if (ph == kvt_pkg::PHASE_REST && pos >= cfg_band_low) begin
            ph = kvt_pkg::PHASE_ARMED;
            cell_arm_ms[cell_idx] = now;
         end
         if (ph == kvt_pkg::PHASE_ARMED) begin
            if (pos >= cfg_band_high) begin
               elapsed = now - cell_arm_ms[cell_idx];
               // The fast test comes first, so fast not below slow never divides.
               if (elapsed <= 32'(cfg_fast_ms)) begin
                  ev.velocity = kvt_pkg::VEL_MAX;
               end else if (elapsed >= 32'(cfg_slow_ms)) begin
                  ev.velocity = '0;
               end else begin
                  num  = (64'(cfg_slow_ms) - 64'(elapsed)) * 64'(kvt_pkg::VEL_MAX);
                  span = 64'(cfg_slow_ms) - 64'(cfg_fast_ms);
                  ev.velocity = 10'(num / span);
               end
               ev.kind = kvt_pkg::EV_PRESS;
               ph = kvt_pkg::PHASE_HELD;
            end else if (pos < cfg_band_low) begin
               ph = kvt_pkg::PHASE_REST;
            end
         end else if (ph == kvt_pkg::PHASE_HELD) begin
            if (pos <= cfg_release) begin
               ev.kind = kvt_pkg::EV_RELEASE;
               ph = kvt_pkg::PHASE_REST;
            end
         end
         cell_phase[cell_idx] = ph;
         ev.held = (ph == kvt_pkg::PHASE_HELD);
      end
      return ev;
   endfunction

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random depth within a band; any depth when the band is empty.
   function automatic logic [11:0] pos_between(int lo, int hi);
      if (hi < lo) return 12'($urandom_range(4095, 0));
      return 12'($urandom_range(hi, lo));
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("%0t mismatch: %s", $time, what);
   endtask

   // Offers one item and records its expected result once accepted.
   task automatic send_sample(input logic [7:0] cell_idx, input logic [11:0] pos,
                              input logic [31:0] now);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_index <= cell_idx;
      req_position   <= pos;
      req_time_ms    <= now;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_events.push_back(predict_key_event(cell_idx, pos, now));
      if (cell_idx < CELLS) sample_count++;
   endtask

   // Lets every outstanding result drain, then a short pause before any register write.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         kvt_pkg::CSR_BAND_LOW:  cfg_band_low  = value[11:0];
         kvt_pkg::CSR_BAND_HIGH: cfg_band_high = value[11:0];
         kvt_pkg::CSR_RELEASE:   cfg_release   = value[11:0];
         kvt_pkg::CSR_FAST_TIME: cfg_fast_ms   = value;
         kvt_pkg::CSR_SLOW_TIME: cfg_slow_ms   = value;
         default: ;
      endcase
   endtask

   // Writes all five registers; the level registers get random unused upper bits.
   task automatic apply_levels(input int low, input int high, input int rel,
                               input int fast, input int slow);
      write_register(kvt_pkg::CSR_BAND_LOW,  {4'($urandom()), 12'(low)});
      write_register(kvt_pkg::CSR_BAND_HIGH, {4'($urandom()), 12'(high)});
      write_register(kvt_pkg::CSR_RELEASE,   {4'($urandom()), 12'(rel)});
      write_register(kvt_pkg::CSR_FAST_TIME, 16'(fast));
      write_register(kvt_pkg::CSR_SLOW_TIME, 16'(slow));
   endtask

   // One key stroke on a cell: approach, arm, maybe abort, press, hold and release.
   task automatic play_stroke(input logic [7:0] cell_idx);
      logic [31:0] t0;
      logic [31:0] elapsed;
      int          low;
      int          high;
      int          rel;
      int          reach;
      t0    = $urandom();
      low   = cfg_band_low;
      high  = cfg_band_high;
      rel   = cfg_release;
      reach = (cfg_slow_ms > cfg_fast_ms) ? cfg_slow_ms : cfg_fast_ms;
      if ($urandom_range(0, 9) == 0) elapsed = $urandom();
      else elapsed = $urandom_range(reach + 8, 0);
      if ($urandom_range(0, 3) == 0 && low > 0)
         send_sample(cell_idx, pos_between(0, low - 1), t0 - 5);
      // Most strokes arm first; the rest go from rest to press in one deep sample.
      if ($urandom_range(0, 3) != 0) begin
         send_sample(cell_idx, pos_between(low, high - 1), t0);
         if ($urandom_range(0, 4) == 0 && low > 0) begin
            send_sample(cell_idx, pos_between(0, low - 1), t0 + 1);
            return;
         end
         if ($urandom_range(0, 1) == 0)
            send_sample(cell_idx, pos_between(low, high - 1), t0 + 1);
      end
      send_sample(cell_idx, pos_between(high, 4095), t0 + elapsed);
      repeat ($urandom_range(2, 0)) send_sample(cell_idx, pos_between(rel + 1, 4095), $urandom());
      send_sample(cell_idx, pos_between(0, rel), $urandom());
   endtask

   // Reset settings: arming, cascade, timing bands, wrap, abort and cells out of range.
   task automatic test_directed_strokes();
      send_sample(8'd0, 12'd1229, 32'd100);
      send_sample(8'd0, 12'd3277, 32'd101);
      send_sample(8'd0, 12'd4095, 32'd200);
      send_sample(8'd0, 12'd819, 32'd201);
      send_sample(8'd1, 12'd1300, 32'd1000);
      send_sample(8'd1, 12'd3300, 32'd1026);
      send_sample(8'd1, 12'd0, 32'd1100);
      send_sample(8'd2, 12'd4095, 32'd5);
      send_sample(8'd2, 12'd820, 32'd6);
      send_sample(8'd2, 12'd819, 32'd7);
      // Timestamp wraps between arming and press.
      send_sample(8'd3, 12'd2000, 32'hFFFF_FFF0);
      send_sample(8'd3, 12'd3500, 32'h0000_0020);
      send_sample(8'd3, 12'd0, 32'hFFFF_FFFF);
      // Armed cell falls back below the band: silent return to rest.
      send_sample(8'd4, 12'd1229, 32'd50);
      send_sample(8'd4, 12'd1228, 32'd51);
      send_sample(8'd5, 12'd2000, 32'd10);
      send_sample(8'd5, 12'd3277, 32'd60);
      send_sample(8'd5, 12'd0, 32'd61);
      send_sample(8'd6, 12'd0, 32'd0);
      send_sample(8'(CELLS - 1), 12'd4095, 32'd9);
      send_sample(8'(CELLS), 12'd4095, 32'd9);
      send_sample(8'd255, 12'd4095, 32'hFFFF_FFFF);
      send_sample(8'(CELLS - 1), 12'd0, 32'd10);
   endtask

   // Fast time at or above slow time: full velocity or none, no division.
   task automatic test_fast_not_below_slow();
      wait_quiet();
      apply_levels(kvt_pkg::BAND_LOW_RESET, kvt_pkg::BAND_HIGH_RESET,
                   kvt_pkg::RELEASE_RESET, 100, 20);
      send_sample(8'd7, 12'd2000, 32'd1000);
      send_sample(8'd7, 12'd4000, 32'd1050);
      send_sample(8'd7, 12'd100, 32'd1060);
      send_sample(8'd7, 12'd2000, 32'd2000);
      send_sample(8'd7, 12'd4000, 32'd2150);
      send_sample(8'd7, 12'd100, 32'd2160);
      wait_quiet();
      apply_levels(kvt_pkg::BAND_LOW_RESET, kvt_pkg::BAND_HIGH_RESET,
                   kvt_pkg::RELEASE_RESET, 30, 30);
      send_sample(8'd8, 12'd2000, 32'd0);
      send_sample(8'd8, 12'd4000, 32'd30);
      send_sample(8'd8, 12'd0, 32'd40);
      send_sample(8'd8, 12'd2000, 32'd100);
      send_sample(8'd8, 12'd4000, 32'd131);
      send_sample(8'd8, 12'd0, 32'd140);
   endtask

   // Levels and times at the ends of their ranges.
   task automatic test_extreme_levels();
      wait_quiet();
      apply_levels(0, 0, 0, 0, 65535);
      send_sample(8'd9, 12'd0, 32'd0);
      send_sample(8'd9, 12'd0, 32'd1);
      wait_quiet();
      apply_levels(4095, 4095, 4095, 65535, 0);
      send_sample(8'd10, 12'd4094, 32'd0);
      send_sample(8'd10, 12'd4095, 32'd1);
      send_sample(8'd10, 12'd4095, 32'd2);
      wait_quiet();
      apply_levels(4095, 4095, 0, 0, 65535);
      send_sample(8'd11, 12'd4095, 32'd0);
      send_sample(8'd11, 12'd0, 32'd0);
      send_sample(8'd11, 12'd4095, 32'hFFFF_FFFF);
      send_sample(8'd11, 12'd4095, 32'd0);
      send_sample(8'd11, 12'd4095, 32'd1);
      send_sample(8'd11, 12'd0, 32'd2);
   endtask

   // Random strokes under a sequence of settings, with occasional noise items.
   task automatic test_random_strokes();
      int setting;
      int first;
      int low;
      int fast;
      for (setting = 0; setting < 6; setting++) begin
         wait_quiet();
         case (setting % 4)
            0: apply_levels(kvt_pkg::BAND_LOW_RESET, kvt_pkg::BAND_HIGH_RESET,
                            kvt_pkg::RELEASE_RESET, kvt_pkg::FAST_TIME_RESET,
                            kvt_pkg::SLOW_TIME_RESET);
            1: begin
               low  = $urandom_range(2000, 1);
               fast = $urandom_range(20, 0);
               apply_levels(low, $urandom_range(4095, low + 1), $urandom_range(low - 1, 0),
                            fast, $urandom_range(fast + 200, fast + 1));
            end
            2: apply_levels($urandom_range(2000, 0), $urandom_range(4095, 2000),
                            $urandom_range(1000, 0), 0, 65535);
            default: apply_levels($urandom_range(4095, 0), $urandom_range(4095, 0),
                                  $urandom_range(4095, 0), $urandom_range(65535, 0),
                                  $urandom_range(300, 0));
         endcase
         idle_on  = (setting % 3 != 1);
         stall_on = (setting % 3 != 2);
         first = sample_count;
         while (sample_count - first < ITEMS_PER_SET) begin
            if ($urandom_range(0, 19) == 0) begin
               idle_on  = $urandom_range(0, 1);
               stall_on = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 6) == 0)
               send_sample(8'($urandom()), 12'($urandom()), $urandom());
            else
               play_stroke(8'($urandom_range(CELLS - 1, 0)));
         end
      end
   endtask

   // Result side: random stretches of back-pressure.
   initial begin : rsp_stall
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (stall_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            hold = pick_gap();
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(5, 0);
         end
      end
   end

   // Each accepted result item is compared with the oldest prediction.
   always @(posedge clock) begin : check_events
      key_event_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event for cell %0d", rsp_event_cell));
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind)
               report_mismatch($sformatf("cell %0d kind %0d, want %0d",
                                         want.cell_id, rsp_event_kind, want.kind));
            if (rsp_event_cell !== want.cell_id)
               report_mismatch($sformatf("cell %0d, want %0d", rsp_event_cell, want.cell_id));
            if (rsp_velocity !== want.velocity)
               report_mismatch($sformatf("cell %0d velocity %0d, want %0d",
                                         want.cell_id, rsp_velocity, want.velocity));
            if (rsp_is_held !== want.held)
               report_mismatch($sformatf("cell %0d held %0b, want %0b",
                                         want.cell_id, rsp_is_held, want.held));
         end
      end
   end

   // Ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[key_velocity_tracker_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin : run_tests
      int i;
      for (i = 0; i < CELLS; i++) begin
         cell_phase[i]  = kvt_pkg::PHASE_REST;
         cell_arm_ms[i] = '0;
      end
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cell_index   = '0;
      req_position     = '0;
      req_time_ms      = '0;
      csr_write_enable = 1'b0;
      csr_index        = kvt_pkg::CSR_BAND_LOW;
      csr_write_data   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_strokes();
      test_fast_not_below_slow();
      test_extreme_levels();
      test_random_strokes();

      wait_quiet();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("[key_velocity_tracker_unit] OK");
      else $display("[key_velocity_tracker_unit] ERROR");
      $finish;
   end

endmodule
